@@ rtl/fhm_pkg.sv @@
// ----------------------------------------------------------------------------
// fhm_pkg
// Shared types and constants of the fire heat map stencil.
// ----------------------------------------------------------------------------
package fhm_pkg;

  localparam int HEAT_W   = 16;
  localparam int COORD_W  = 6;
  localparam int ACT_W    = 2;
  localparam int GEOM_W   = 7;
  localparam int DAMP_W   = 16;
  localparam int COLOUR_W = 8;

  // five taps of HEAT_W bits
  localparam int SUM_W   = HEAT_W + 3;
  localparam int PROD_W  = SUM_W + DAMP_W;
  // floor(x / 5) = (x * DIV5_RECIP) >> DIV5_SHIFT for x below 2**21 / 3
  localparam int RECIP_W = 19;
  localparam logic [RECIP_W-1:0] DIV5_RECIP = 19'd419431;
  localparam int DIV5_SHIFT = 21;
  localparam int QUO_W   = SUM_W + RECIP_W;

  localparam logic [HEAT_W-1:0] HEAT_FULL = 16'hFFFF;
  localparam logic [HEAT_W-1:0] HEAT_ZERO = 16'h0000;

  localparam logic [HEAT_W-1:0] THR_WHITE  = 16'd32768;
  localparam logic [HEAT_W-1:0] THR_ORANGE = 16'd26214;
  localparam logic [HEAT_W-1:0] THR_RED    = 16'd19660;
  localparam logic [HEAT_W-1:0] THR_GREY   = 16'd14417;

  localparam int MIN_COLS   = 3;
  localparam int MIN_ROWS   = 2;
  localparam int SEED_CELLS = 6;
  localparam int SEED_W     = 3;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [GEOM_W-1:0] RST_GRID_WIDTH  = 7'd53;
  localparam logic [GEOM_W-1:0] RST_GRID_HEIGHT = 7'd15;
  localparam logic [DAMP_W-1:0] RST_DAMPING     = 16'd62259;
  localparam logic              RST_TRANSPOSE   = 1'b0;

  typedef enum logic [1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_DAMPING   = 2'd2,
    REG_TRANSPOSE = 2'd3
  } reg_idx_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_RENDER   = 2'd0,
    ACT_CLR_CELL = 2'd1,
    ACT_SEED     = 2'd2,
    ACT_CLR_MAP  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    TAP_OWN    = 3'd0,
    TAP_BELOW  = 3'd1,
    TAP_LEFT   = 3'd2,
    TAP_RIGHT  = 3'd3,
    TAP_BELOW2 = 3'd4
  } tap_t;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_ACC   = 6'b001000,
    ST_MUL   = 6'b010000,
    ST_SEED  = 6'b100000
  } state_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t                colour;
    logic [COORD_W-1:0]  disp_x;
    logic [COORD_W-1:0]  disp_y;
    logic [HEAT_W-1:0]   new_heat;
  } result_t;

  function automatic rgb_t palette(input logic [HEAT_W-1:0] heat);
    rgb_t c;
    if (heat > THR_WHITE) begin
      c = '{red: 8'd255, green: 8'd255, blue: 8'd180};
    end else if (heat > THR_ORANGE) begin
      c = '{red: 8'd220, green: 8'd160, blue: 8'd0};
    end else if (heat > THR_RED) begin
      c = '{red: 8'd180, green: 8'd30, blue: 8'd0};
    end else if (heat > THR_GREY) begin
      c = '{red: 8'd20, green: 8'd20, blue: 8'd20};
    end else begin
      c = '{red: 8'd0, green: 8'd0, blue: 8'd0};
    end
    return c;
  endfunction

endpackage

@@ rtl/fire_heat_map_stencil.sv @@
// ----------------------------------------------------------------------------
// fire_heat_map_stencil
// Fire effect heat map: render/cool one cell per word, clear, seed, wipe.
//
//   channel | signals                                  | flow
//   --------+------------------------------------------+-----------------------
//   input   | start, busy, in_action, in_col, in_row   | taken on start & !busy
//   result  | out_strobe, out_red..out_new_heat        | one cycle, no stall
//   config  | psel, penable, pwrite, paddr, pwdata ... | APB, pready tied high
//
// Render word: five reads on the single heat store read port, a sum step
// and the two damping multiply stages; the next start waits for idle.
// Render outside the grid and bottom-cell clear leave the block idle. Seed: six cells.
// Reset and clear map: a sweep over all MAX_COLS*MAX_ROWS cells (4096 by default)
// zeroes the store with busy high; config writes are still taken.
// Result appears the cycle after the write-back and cannot be held off.
// ----------------------------------------------------------------------------
module fire_heat_map_stencil #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [fhm_pkg::ACT_W-1:0]    in_action,
  input  logic [fhm_pkg::COORD_W-1:0]  in_col,
  input  logic [fhm_pkg::COORD_W-1:0]  in_row,
  output logic                         out_strobe,
  output logic [fhm_pkg::COLOUR_W-1:0] out_red,
  output logic [fhm_pkg::COLOUR_W-1:0] out_green,
  output logic [fhm_pkg::COLOUR_W-1:0] out_blue,
  output logic [fhm_pkg::COORD_W-1:0]  out_disp_x,
  output logic [fhm_pkg::COORD_W-1:0]  out_disp_y,
  output logic [fhm_pkg::HEAT_W-1:0]   out_new_heat,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fhm_pkg::CFG_AW-1:0]   paddr,
  input  logic [fhm_pkg::CFG_DW-1:0]   pwdata,
  output logic [fhm_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);
  import fhm_pkg::*;

  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int SCW   = (CW > GEOM_W) ? CW : GEOM_W;
  localparam int SRW   = (RW > GEOM_W) ? RW : GEOM_W;
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);

  logic [GEOM_W-1:0] grid_width_r, grid_height_r;
  logic [DAMP_W-1:0] damping_r;
  logic              transpose_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  logic [SCW-1:0] gw;
  logic [SRW-1:0] gh;
  logic [CW-1:0]  cols_use;
  logic [RW-1:0]  rows_use;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [HEAT_W-1:0] mem_wdata, mem_rdata;
  logic              dmp_go, dmp_done;
  logic [SUM_W-1:0]  dmp_sum;
  logic [HEAT_W-1:0] dmp_heat;
  result_t           res;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= RST_GRID_WIDTH;
      grid_height_r <= RST_GRID_HEIGHT;
      damping_r     <= RST_DAMPING;
      transpose_r   <= RST_TRANSPOSE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:     grid_width_r  <= pwdata[GEOM_W-1:0];
        REG_HEIGHT:    grid_height_r <= pwdata[GEOM_W-1:0];
        REG_DAMPING:   damping_r     <= pwdata[DAMP_W-1:0];
        REG_TRANSPOSE: transpose_r   <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_WIDTH:     prdata = CFG_DW'(grid_width_r);
      REG_HEIGHT:    prdata = CFG_DW'(grid_height_r);
      REG_DAMPING:   prdata = CFG_DW'(damping_r);
      REG_TRANSPOSE: prdata = CFG_DW'(transpose_r);
    endcase
  end

  // grid size in use, raised to the minimum and saturated to the store
  assign gw = SCW'(grid_width_r);
  assign gh = SRW'(grid_height_r);

  always_comb begin
    if (gw < SCW'(MIN_COLS)) begin
      cols_use = CW'(MIN_COLS);
    end else if (gw > SCW'(MAX_COLS)) begin
      cols_use = CW'(MAX_COLS);
    end else begin
      cols_use = CW'(gw);
    end
    if (gh < SRW'(MIN_ROWS)) begin
      rows_use = RW'(MIN_ROWS);
    end else if (gh > SRW'(MAX_ROWS)) begin
      rows_use = RW'(MAX_ROWS);
    end else begin
      rows_use = RW'(gh);
    end
  end

  fhm_heat_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fhm_damp u_damp (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (dmp_go),
    .sum     (dmp_sum),
    .damping (damping_r),
    .done    (dmp_done),
    .heat    (dmp_heat)
  );

  fhm_seq #(
    .MAX_COLS (MAX_COLS),
    .CW       (CW),
    .RW       (RW),
    .DEPTH    (DEPTH),
    .AW       (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .action    (in_action),
    .col       (in_col),
    .row       (in_row),
    .cols_use  (cols_use),
    .rows_use  (rows_use),
    .transpose (transpose_r),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .dmp_go    (dmp_go),
    .dmp_sum   (dmp_sum),
    .dmp_done  (dmp_done),
    .dmp_heat  (dmp_heat),
    .res_vld   (out_strobe),
    .res       (res)
  );

  assign out_red      = res.colour.red;
  assign out_green    = res.colour.green;
  assign out_blue     = res.colour.blue;
  assign out_disp_x   = res.disp_x;
  assign out_disp_y   = res.disp_y;
  assign out_new_heat = res.new_heat;

`ifndef NO_ASSERTIONS
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a word in flight");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back-to-back result strobes");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == ACT_CLR_MAP) |=> busy)
    else $error("clear map did not start the sweep");

  a_damp_write: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr[3:2] == REG_DAMPING)
      |=> damping_r == $past(pwdata[DAMP_W-1:0]))
    else $error("damping register write lost");
`endif

endmodule

@@ rtl/fhm_heat_mem.sv @@
// ----------------------------------------------------------------------------
// fhm_heat_mem
// Heat store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fhm_heat_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [fhm_pkg::HEAT_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [fhm_pkg::HEAT_W-1:0] rdata
);
  import fhm_pkg::*;

  logic [HEAT_W-1:0] mem [DEPTH];
  logic [HEAT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/fhm_damp.sv @@
// ----------------------------------------------------------------------------
// fhm_damp
// Damping pipeline: floor(sum * damping / (5 * 65536)), two multiply stages.
// ----------------------------------------------------------------------------
module fhm_damp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [fhm_pkg::SUM_W-1:0]  sum,
  input  logic [fhm_pkg::DAMP_W-1:0] damping,
  output logic                       done,
  output logic [fhm_pkg::HEAT_W-1:0] heat
);
  import fhm_pkg::*;

  logic               vld1_r;
  logic               vld2_r;
  logic [PROD_W-1:0]  prod_r;
  logic [QUO_W-1:0]   quo_r;
  logic [SUM_W-1:0]   scaled;

  // drop the Q0.16 fraction, then divide by five
  assign scaled = prod_r[PROD_W-1:DAMP_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= go;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(sum) * PROD_W'(damping);
    quo_r  <= QUO_W'(scaled) * QUO_W'(DIV5_RECIP);
  end

  assign done = vld2_r;
  assign heat = quo_r[DIV5_SHIFT +: HEAT_W];

endmodule

@@ rtl/fhm_seq.sv @@
// ----------------------------------------------------------------------------
// fhm_seq
// Action sequencer: clearing sweep, bottom-cell clear, tap reads, seed writes and write-back.
// ----------------------------------------------------------------------------
module fhm_seq #(
  parameter int MAX_COLS = 64,
  parameter int CW       = 7,
  parameter int RW       = 7,
  parameter int DEPTH    = 4096,
  parameter int AW       = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [fhm_pkg::ACT_W-1:0]   action,
  input  logic [fhm_pkg::COORD_W-1:0] col,
  input  logic [fhm_pkg::COORD_W-1:0] row,
  input  logic [CW-1:0]               cols_use,
  input  logic [RW-1:0]               rows_use,
  input  logic                        transpose,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [fhm_pkg::HEAT_W-1:0]  mem_wdata,
  output logic [AW-1:0]               mem_raddr,
  input  logic [fhm_pkg::HEAT_W-1:0]  mem_rdata,
  output logic                        dmp_go,
  output logic [fhm_pkg::SUM_W-1:0]   dmp_sum,
  input  logic                        dmp_done,
  input  logic [fhm_pkg::HEAT_W-1:0]  dmp_heat,
  output logic                        res_vld,
  output fhm_pkg::result_t            res
);
  import fhm_pkg::*;

  localparam int XW = ((CW > COORD_W) ? CW : COORD_W) + 1;
  localparam int YW = ((RW > COORD_W) ? RW : COORD_W) + 1;

  state_t            state_r, state_nxt;
  tap_t              tap_r, tap_nxt;
  logic [SEED_W-1:0] seed_r, seed_nxt;
  logic [AW-1:0]     sweep_r, sweep_nxt;
  logic [XW-1:0]     col_r;
  logic [YW-1:0]     row_r;
  logic              rd_vld_r;
  tap_t              rd_tap_r;
  logic              rd_keep_r;
  logic [HEAT_W-1:0] heat_r;
  logic [SUM_W-1:0]  sum_r;
  logic              go_r;
  logic              res_vld_r;
  result_t           res_r;

  logic [XW-1:0] w, in_c, left, right, tap_c, seed_sum, seed_c;
  logic [YW-1:0] h, in_r, r1, r2, tap_y, seed_y;
  logic [SEED_W-1:0] seed_idx;
  logic          accept, in_grid, tap_keep, seed_ok;
  action_t       act;

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] c,
                                              input logic [YW-1:0] r);
    return AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  assign w       = XW'(cols_use);
  assign h       = YW'(rows_use);
  assign in_c    = XW'(col);
  assign in_r    = YW'(row);
  assign in_grid = (in_c < w) && (in_r < h);
  assign act     = action_t'(action);
  assign accept  = start && (state_r == ST_IDLE);

  assign r1    = row_r + YW'(1);
  assign r2    = row_r + YW'(2);
  assign left  = (col_r == '0) ? '0 : col_r - XW'(1);
  assign right = ((col_r + XW'(1)) >= w) ? w - XW'(1) : col_r + XW'(1);

  // rows below the grid read as zero: keep own row as a safe address
  always_comb begin
    tap_c    = col_r;
    tap_y    = row_r;
    tap_keep = 1'b1;
    case (tap_r)
      TAP_OWN: begin
        tap_c = col_r;
      end
      TAP_BELOW: begin
        tap_keep = r1 < h;
        tap_y    = tap_keep ? r1 : row_r;
      end
      TAP_LEFT: begin
        tap_keep = r1 < h;
        tap_c    = left;
        tap_y    = tap_keep ? r1 : row_r;
      end
      TAP_RIGHT: begin
        tap_keep = r1 < h;
        tap_c    = right;
        tap_y    = tap_keep ? r1 : row_r;
      end
      TAP_BELOW2: begin
        tap_keep = r2 < h;
        tap_y    = tap_keep ? r2 : row_r;
      end
      default: begin
        tap_keep = 1'b0;
      end
    endcase
  end

  // patch cell: column col-1+idx, row h-2 then h-1
  assign seed_idx = (seed_r >= SEED_W'(3)) ? seed_r - SEED_W'(3) : seed_r;
  assign seed_sum = col_r + XW'(seed_idx);
  assign seed_c   = seed_sum - XW'(1);
  assign seed_ok  = (seed_sum != '0) && (seed_c < w);
  assign seed_y   = (seed_r < SEED_W'(3)) ? h - YW'(2) : h - YW'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_r;
    mem_wdata = HEAT_ZERO;
    mem_raddr = cell_addr(tap_c, tap_y);
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        mem_we    = accept && (act == ACT_CLR_CELL) && (in_c < w);
        mem_waddr = cell_addr(in_c, h - YW'(1));
      end
      ST_SEED: begin
        mem_we    = seed_ok;
        mem_waddr = cell_addr(seed_c, seed_y);
        mem_wdata = HEAT_FULL;
      end
      ST_MUL: begin
        mem_we    = dmp_done;
        mem_waddr = cell_addr(col_r, row_r);
        mem_wdata = dmp_heat;
      end
      ST_READ, ST_ACC: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    seed_nxt  = seed_r;
    sweep_nxt = sweep_r;
    unique case (state_r)
      ST_CLEAR: begin
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          unique case (act)
            ACT_RENDER: begin
              tap_nxt = TAP_OWN;
              if (in_grid) begin
                state_nxt = ST_READ;
              end
            end
            ACT_CLR_CELL: begin
              state_nxt = ST_IDLE;
            end
            ACT_SEED: begin
              seed_nxt  = '0;
              state_nxt = ST_SEED;
            end
            ACT_CLR_MAP: begin
              sweep_nxt = '0;
              state_nxt = ST_CLEAR;
            end
          endcase
        end
      end
      ST_READ: begin
        tap_nxt = tap_t'(tap_r + 3'd1);
        if (tap_r == TAP_BELOW2) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (dmp_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SEED: begin
        seed_nxt = seed_r + SEED_W'(1);
        if (seed_r == SEED_W'(SEED_CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      tap_r     <= TAP_OWN;
      seed_r    <= '0;
      sweep_r   <= '0;
      rd_vld_r  <= 1'b0;
      rd_tap_r  <= TAP_OWN;
      go_r      <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tap_r     <= tap_nxt;
      seed_r    <= seed_nxt;
      sweep_r   <= sweep_nxt;
      rd_vld_r  <= state_r == ST_READ;
      rd_tap_r  <= tap_r;
      go_r      <= state_r == ST_ACC;
      res_vld_r <= (state_r == ST_MUL) && dmp_done;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_r <= in_c;
      row_r <= in_r;
    end
    rd_keep_r <= tap_keep;
    if (rd_vld_r) begin
      if (rd_tap_r == TAP_OWN) begin
        heat_r <= mem_rdata;
        sum_r  <= SUM_W'(mem_rdata);
      end else begin
        sum_r <= sum_r + (rd_keep_r ? SUM_W'(mem_rdata) : '0);
      end
    end
    if ((state_r == ST_MUL) && dmp_done) begin
      res_r.colour   <= palette(heat_r);
      res_r.disp_x   <= transpose ? row_r[COORD_W-1:0] : col_r[COORD_W-1:0];
      res_r.disp_y   <= transpose ? col_r[COORD_W-1:0] : row_r[COORD_W-1:0];
      res_r.new_heat <= dmp_heat;
    end
  end

  assign busy    = state_r != ST_IDLE;
  assign dmp_go  = go_r;
  assign dmp_sum = sum_r;
  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule
